// ----- design/brsci_pkg.sv -----
// ----------------------------------------------------------------------------
// brsci_pkg
// Shared sizes, types and helpers for the rectangle set/clear/invert bitmap.
// ----------------------------------------------------------------------------
package brsci_pkg;

  localparam int GRID_SIDE = 1024;
  localparam int COORD_W   = 10;
  localparam int COUNT_W   = 21;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int POP_W     = 7;

  localparam int ROW_WORDS = (GRID_SIDE + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int WORD_W    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int ADDR_W    = ROW_W + WORD_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int CRD_W     = (ROW_W > COORD_W) ? ROW_W : COORD_W;

  typedef enum logic [1:0] {
    FN_SET    = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_INVERT = 2'd2
  } func_t;

  // One rectangle, already clamped and split into rows, words and bit offsets.
  typedef struct packed {
    func_t              func;
    logic               noop;
    logic [ROW_W-1:0]   row_lo;
    logic [ROW_W-1:0]   row_hi;
    logic [WORD_W-1:0]  word_lo;
    logic [WORD_W-1:0]  word_hi;
    logic [BIT_W-1:0]   bit_lo;
    logic [BIT_W-1:0]   bit_hi;
  } cmd_t;

  // One word access handed from the walker to the update pipeline.
  typedef struct packed {
    logic                 v;
    logic                 wipe;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] mask;
    func_t                func;
  } op_t;

  // Pairwise adder tree, so the depth grows with the log of the word width.
  function automatic logic [POP_W-1:0] ones_in(input logic [WORD_BITS-1:0] v);
    logic [POP_W-1:0] s [WORD_BITS];
    for (int i = 0; i < WORD_BITS; i++) begin
      s[i] = POP_W'(v[i]);
    end
    for (int step = 1; step < WORD_BITS; step = step * 2) begin
      for (int i = 0; i + step < WORD_BITS; i = i + 2 * step) begin
        s[i] = s[i] + s[i + step];
      end
    end
    return s[0];
  endfunction

endpackage

// ----- design/brsci_ram.sv -----
// ----------------------------------------------------------------------------
// brsci_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module brsci_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/brsci_walk.sv -----
// ----------------------------------------------------------------------------
// brsci_walk
// Address sequencer: clears the bitmap after reset, then walks each rectangle
// one word at a time, row by row, and builds the bit mask for every word.
// ----------------------------------------------------------------------------
module brsci_walk (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  brsci_pkg::cmd_t cmd,
  input  logic            upd_busy,
  output logic            idle,
  output logic            done,
  output brsci_pkg::op_t  issue
);
  import brsci_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  cmd_t              cmd_q;
  logic [ROW_W-1:0]  row;
  logic [WORD_W-1:0] word;
  logic [BIT_W-1:0]  lo_bit;
  logic [BIT_W-1:0]  hi_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(RAM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: if (start) begin
          cmd_q <= cmd;
          row   <= cmd.row_lo;
          word  <= cmd.word_lo;
          state <= cmd.noop ? ST_DRAIN : ST_RUN;
        end
        ST_RUN: if (word == cmd_q.word_hi) begin
          word <= cmd_q.word_lo;
          if (row == cmd_q.row_hi) begin
            state <= ST_DRAIN;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          word <= word + 1'b1;
        end
        ST_DRAIN: if (!upd_busy) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Only the first and last word of a row are partly covered.
  always_comb begin
    lo_bit     = (word == cmd_q.word_lo) ? cmd_q.bit_lo : '0;
    hi_bit     = (word == cmd_q.word_hi) ? cmd_q.bit_hi : '1;
    issue.v    = (state == ST_CLEAR) || (state == ST_RUN);
    issue.wipe = (state == ST_CLEAR);
    issue.addr = (state == ST_CLEAR) ? clr_addr : {row, word};
    issue.mask = ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit))
               & ({WORD_BITS{1'b1}} << lo_bit);
    issue.func = cmd_q.func;
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DRAIN) && !upd_busy;

endmodule

// ----- design/brsci_update.sv -----
// ----------------------------------------------------------------------------
// brsci_update
// Read-modify-write pipeline: applies the operation to each word read back,
// writes it, and keeps the running count of lit cells.
// ----------------------------------------------------------------------------
module brsci_update (
  input  logic                            clk,
  input  logic                            rst,
  input  brsci_pkg::op_t                  issue,
  input  logic [brsci_pkg::WORD_BITS-1:0] rdata,
  output logic                            we,
  output logic [brsci_pkg::ADDR_W-1:0]    waddr,
  output logic [brsci_pkg::WORD_BITS-1:0] wdata,
  output logic                            busy,
  output logic [brsci_pkg::COUNT_W-1:0]   count
);
  import brsci_pkg::*;

  op_t                  p1;
  logic                 p2_v;
  logic [WORD_BITS-1:0] p2_old;
  logic [WORD_BITS-1:0] p2_new;
  logic                 p3_v;
  logic [POP_W-1:0]     p3_old;
  logic [POP_W-1:0]     p3_new;
  logic [WORD_BITS-1:0] nw;

  always_comb begin
    case (p1.func)
      FN_SET:    nw = rdata | p1.mask;
      FN_CLEAR:  nw = rdata & ~p1.mask;
      FN_INVERT: nw = rdata ^ p1.mask;
      default:   nw = rdata;
    endcase
  end

  assign we    = p1.v;
  assign waddr = p1.addr;
  assign wdata = p1.wipe ? '0 : nw;
  assign busy  = p1.v || p2_v || p3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      count <= '0;
    end else begin
      p1   <= issue;
      p2_v <= p1.v && !p1.wipe;
      p3_v <= p2_v;
      if (p3_v) begin
        count <= count + COUNT_W'(p3_new) - COUNT_W'(p3_old);
      end
    end
    p2_old <= rdata & p1.mask;
    p2_new <= nw & p1.mask;
    p3_old <= ones_in(p2_old);
    p3_new <= ones_in(p2_new);
  end

endmodule

// ----- design/bitmap_rectangle_set_clear_invert.sv -----
// ----------------------------------------------------------------------------
// bitmap_rectangle_set_clear_invert
// Set, clear or invert a rectangle of a square bitmap; report lit cells.
// Each rectangle covers N words, where N is rows x words-per-row of the
//   rectangle, walked one 64-bit word per cycle through the bitmap RAM; an empty
//   rectangle or an unused code issues no words.
// Throughput: one rectangle at a time, next word taken in the cycle after the
//   result moves to the output; worst case N = 1024 rows x 16 words = 16384.
// Reset: the count clears at once; a pass over RAM_DEPTH (16384) words then
//   zeroes the bitmap, with in_ready low until it ends.
// ----------------------------------------------------------------------------
module bitmap_rectangle_set_clear_invert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [brsci_pkg::COORD_W-1:0] x_low,
  input  logic [brsci_pkg::COORD_W-1:0] y_low,
  input  logic [brsci_pkg::COORD_W-1:0] x_high,
  input  logic [brsci_pkg::COORD_W-1:0] y_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brsci_pkg::COUNT_W-1:0] lit_total
);
  import brsci_pkg::*;

  localparam logic [CRD_W-1:0] GRID_MAX = CRD_W'(GRID_SIDE - 1);

  logic                 busy;
  logic                 pending;
  logic                 accept;
  logic                 xfer;
  logic [CRD_W-1:0]     xl;
  logic [CRD_W-1:0]     yl;
  logic [CRD_W-1:0]     xh;
  logic [CRD_W-1:0]     yh;
  cmd_t                 cmd;
  logic                 walk_idle;
  logic                 walk_done;
  logic                 upd_busy;
  op_t                  issue;
  logic [WORD_BITS-1:0] rdata;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [COUNT_W-1:0]   count;

  // High bounds past the grid saturate to its last column or row.
  always_comb begin
    xl = CRD_W'(x_low);
    yl = CRD_W'(y_low);
    xh = CRD_W'(x_high);
    yh = CRD_W'(y_high);
    if (xh > GRID_MAX) begin
      xh = GRID_MAX;
    end
    if (yh > GRID_MAX) begin
      yh = GRID_MAX;
    end
    cmd.func    = func_t'(func);
    cmd.noop    = !(func inside {FN_SET, FN_CLEAR, FN_INVERT}) || (xl > xh) || (yl > yh);
    cmd.row_lo  = ROW_W'(yl);
    cmd.row_hi  = ROW_W'(yh);
    cmd.word_lo = WORD_W'(xl >> BIT_W);
    cmd.word_hi = WORD_W'(xh >> BIT_W);
    cmd.bit_lo  = xl[BIT_W-1:0];
    cmd.bit_hi  = xh[BIT_W-1:0];
  end

  assign in_ready = !busy && walk_idle;
  assign accept   = in_valid && in_ready;
  assign xfer     = pending && (!out_valid || out_ready);

  // The finished count waits in pending until the output word is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (xfer) begin
        busy <= 1'b0;
      end
      if (walk_done) begin
        pending <= 1'b1;
      end else if (xfer) begin
        pending <= 1'b0;
      end
      if (xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (xfer) begin
      lit_total <= count;
    end
  end

  brsci_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .cmd      (cmd),
    .upd_busy (upd_busy),
    .idle     (walk_idle),
    .done     (walk_done),
    .issue    (issue)
  );

  brsci_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue.v && !issue.wipe),
    .raddr (issue.addr),
    .rdata (rdata)
  );

  brsci_update u_update (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .busy  (upd_busy),
    .count (count)
  );

  a_done_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    walk_done |-> busy && !pending)
    else $error("walk finished with no word in flight");

  // The last clearing write may still be in the pipeline when input opens.
  a_ready_not_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pending)
    else $error("input ready while a result is outstanding");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second word taken while one is in progress");

endmodule
